>>> hw/rtl/rkce_pkg.sv
package rkce_pkg;

	// Widths fixed by the word layout
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned CODE_W      = 2;
	localparam int unsigned K_W         = 6;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 6;
	localparam int unsigned MAX_K_DEF   = 32;

	// Reset values of the registers
	localparam logic [K_W-1:0]    KMER_SIZE_RST = K_W'(32);
	localparam logic [CODE_W-1:0] CODE_A_RST    = 2'd0;
	localparam logic [CODE_W-1:0] CODE_T_RST    = 2'd1;
	localparam logic [CODE_W-1:0] CODE_C_RST    = 2'd2;
	localparam logic [CODE_W-1:0] CODE_G_RST    = 2'd3;

	// ASCII upper case letters, and the mask that folds case for letters
	localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;
	localparam logic [CHAR_W-1:0] CASE_FOLD = 8'hDF;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KMER_SIZE    = 3'd0,
		REG_CANON_MAX    = 3'd1,
		REG_CODE_A       = 3'd2,
		REG_CODE_T       = 3'd3,
		REG_CODE_C       = 3'd4,
		REG_CODE_G       = 3'd5
	} reg_idx_t;

	// Settings handed from the register file to the datapath
	typedef struct packed {
		logic [K_W-1:0]    k;          // already clamped to 1..MAX_K
		logic              takes_max;
		logic [CODE_W-1:0] code_a;
		logic [CODE_W-1:0] code_t;
		logic [CODE_W-1:0] code_c;
		logic [CODE_W-1:0] code_g;
		logic              clear_fill; // pulse on a kmer_size write
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] fwd;
		logic [CODE_W-1:0] rev;
	} base_code_t;

	// Forward and complement codes of one character. Clearing bit 5 folds
	// a lower case letter onto upper case; only 'X' and 'x' land on 'X'.
	function automatic base_code_t decode_base(input logic [CHAR_W-1:0] ch, input cfg_t cfg);
		logic [CHAR_W-1:0] up;
		base_code_t        bc;
		up = ch & CASE_FOLD;
		if (up == CHAR_A) begin
			bc.fwd = cfg.code_a;
			bc.rev = cfg.code_t;
		end else if (up == CHAR_T) begin
			bc.fwd = cfg.code_t;
			bc.rev = cfg.code_a;
		end else if (up == CHAR_C) begin
			bc.fwd = cfg.code_c;
			bc.rev = cfg.code_g;
		end else begin
			bc.fwd = cfg.code_g;
			bc.rev = cfg.code_c;
		end
		return bc;
	endfunction

endpackage

>>> hw/rtl/rkce_cfg.sv
module rkce_cfg #(
	parameter int unsigned MAX_K = rkce_pkg::MAX_K_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rkce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rkce_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rkce_pkg::cfg_t                   cfg
);

	logic [rkce_pkg::K_W-1:0]    k_q;
	logic                        takes_max_q;
	logic [rkce_pkg::CODE_W-1:0] code_a_q;
	logic [rkce_pkg::CODE_W-1:0] code_t_q;
	logic [rkce_pkg::CODE_W-1:0] code_c_q;
	logic [rkce_pkg::CODE_W-1:0] code_g_q;
	logic [rkce_pkg::K_W-1:0]    k_clamped;
	logic                        wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	// Size 0 acts as 1, sizes above MAX_K act as MAX_K
	always_comb begin
		if (cfg_data[rkce_pkg::K_W-1:0] == '0) begin
			k_clamped = rkce_pkg::K_W'(1);
		end else if (cfg_data[rkce_pkg::K_W-1:0] > rkce_pkg::K_W'(MAX_K)) begin
			k_clamped = rkce_pkg::K_W'(MAX_K);
		end else begin
			k_clamped = cfg_data[rkce_pkg::K_W-1:0];
		end
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= (rkce_pkg::KMER_SIZE_RST > rkce_pkg::K_W'(MAX_K)) ?
			               rkce_pkg::K_W'(MAX_K) : rkce_pkg::KMER_SIZE_RST;
			takes_max_q <= 1'b0;
			code_a_q    <= rkce_pkg::CODE_A_RST;
			code_t_q    <= rkce_pkg::CODE_T_RST;
			code_c_q    <= rkce_pkg::CODE_C_RST;
			code_g_q    <= rkce_pkg::CODE_G_RST;
		end else if (wr) begin
			case (rkce_pkg::reg_idx_t'(cfg_index))
				rkce_pkg::REG_KMER_SIZE: k_q         <= k_clamped;
				rkce_pkg::REG_CANON_MAX: takes_max_q <= cfg_data[0];
				rkce_pkg::REG_CODE_A:    code_a_q    <= cfg_data[rkce_pkg::CODE_W-1:0];
				rkce_pkg::REG_CODE_T:    code_t_q    <= cfg_data[rkce_pkg::CODE_W-1:0];
				rkce_pkg::REG_CODE_C:    code_c_q    <= cfg_data[rkce_pkg::CODE_W-1:0];
				rkce_pkg::REG_CODE_G:    code_g_q    <= cfg_data[rkce_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// A new size restarts the fill
	always_comb begin
		cfg.k          = k_q;
		cfg.takes_max  = takes_max_q;
		cfg.code_a     = code_a_q;
		cfg.code_t     = code_t_q;
		cfg.code_c     = code_c_q;
		cfg.code_g     = code_g_q;
		cfg.clear_fill = wr &&
		                 (rkce_pkg::reg_idx_t'(cfg_index) == rkce_pkg::REG_KMER_SIZE);
	end

endmodule

>>> hw/rtl/rkce_datapath.sv
module rkce_datapath #(
	parameter int unsigned MAX_K = rkce_pkg::MAX_K_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rkce_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rkce_pkg::CHAR_W-1:0]     in_char,
	input  logic                            in_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rkce_pkg::WORD_W-1:0]     out_fwd,
	output logic [rkce_pkg::WORD_W-1:0]     out_rev,
	output logic [rkce_pkg::WORD_W-1:0]     out_canon,
	output logic                            out_kvalid
);

	localparam int unsigned WW = 2 * MAX_K;

	// Input stage
	logic                        valid_s1;
	logic [rkce_pkg::CHAR_W-1:0] char_s1;
	logic                        start_s1;

	// Rolling state
	logic [WW-1:0]               fwd_q;
	logic [WW-1:0]               rev_q;
	logic [rkce_pkg::K_W-1:0]    fill_q;

	// Result stage
	logic                        valid_s2;
	logic [WW-1:0]               fwd_s2;
	logic [WW-1:0]               rev_s2;
	logic [WW-1:0]               canon_s2;
	logic                        kvalid_s2;

	logic                        adv;
	rkce_pkg::base_code_t        bc;
	logic [WW-1:0]               mask;
	logic [WW-1:0]               fwd_base;
	logic [WW-1:0]               rev_sh;
	logic [WW-1:0]               fwd_n;
	logic [WW-1:0]               rev_n;
	logic [WW-1:0]               canon_n;
	logic [rkce_pkg::K_W-1:0]    fill_base;
	logic [rkce_pkg::K_W-1:0]    fill_n;
	logic                        fwd_less;

	// Handshake: the input stage moves on when the result stage is free
	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= in_char;
			start_s1 <= in_start;
		end
	end

	// Word mask: the low 2k bits
	always_comb begin
		for (int i = 0; i < WW; i++) begin
			mask[i] = (rkce_pkg::K_W'(i >> 1) < cfg.k);
		end
	end

	// Next rolling words
	always_comb begin
		bc        = rkce_pkg::decode_base(char_s1, cfg);
		fwd_base  = start_s1 ? '0 : fwd_q;
		fill_base = start_s1 ? '0 : fill_q;
		rev_sh    = ((start_s1 ? '0 : rev_q) & mask) >> 2;
		fwd_n     = {fwd_base[WW-3:0], bc.fwd} & mask;
		// complement code goes into base slot k-1
		for (int j = 0; j < MAX_K; j++) begin
			rev_n[2*j +: 2] = (rkce_pkg::K_W'(j + 1) == cfg.k) ? bc.rev : rev_sh[2*j +: 2];
		end
		rev_n     = rev_n & mask;
		fill_n    = (fill_base < cfg.k) ? fill_base + rkce_pkg::K_W'(1) : cfg.k;
		fwd_less  = fwd_n < rev_n;
		if (cfg.takes_max) begin
			canon_n = fwd_less ? rev_n : fwd_n;
		end else begin
			canon_n = fwd_less ? fwd_n : rev_n;
		end
	end

	// State update, taken with each word that moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= '0;
		end else if (cfg.clear_fill) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= '0;
		end else if (adv) begin
			fwd_q  <= fwd_n;
			rev_q  <= rev_n;
			fill_q <= fill_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kvalid_s2 <= (fill_n >= cfg.k);
			fwd_s2    <= fwd_n;
			rev_s2    <= rev_n;
			canon_s2  <= canon_n;
		end
	end

	// Words read as zero until k bases have arrived
	assign out_valid  = valid_s2;
	assign out_kvalid = kvalid_s2;
	assign out_fwd    = kvalid_s2 ? rkce_pkg::WORD_W'(fwd_s2) : '0;
	assign out_rev    = kvalid_s2 ? rkce_pkg::WORD_W'(rev_s2) : '0;
	assign out_canon  = kvalid_s2 ? rkce_pkg::WORD_W'(canon_s2) : '0;

endmodule

>>> hw/rtl/rolling_kmer_canonical_encoder.sv
// Rolling canonical k-mer encoder. Feed one ASCII base per word on the slave
// side (start_seq in s_tuser marks the first base of a sequence); each base
// yields one result word on the master side carrying the forward k-mer, its
// reverse complement and the canonical pick (minimum, or maximum when
// canonical_takes_max is set), at two bits per base, newest base lowest in
// the forward word. m_tuser is high once k bases have arrived since the
// start mark; before that the three words read as zero. The block takes one
// base per cycle while m_tready does not stall it: a base waits in the input
// register, then the shift, mask and compare logic updates the rolling words
// and loads the result register. Characters other than A, C, T (either case)
// take the G code. Write registers only while no word is in flight; writing
// kmer_size restarts the fill.
module rolling_kmer_canonical_encoder #(
	parameter int unsigned MAX_K = rkce_pkg::MAX_K_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rkce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rkce_pkg::CFG_DATA_W-1:0] cfg_data,
	// base stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] base_char
	input  logic                            s_tuser,  // [0] start_seq
	// k-mer stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [191:0]                    m_tdata,  // [63:0] forward_word,
	                                                  // [127:64] revcomp_word,
	                                                  // [191:128] canonical_word
	output logic                            m_tuser   // [0] kmer_valid
);

	rkce_pkg::cfg_t                  cfg;
	logic [rkce_pkg::WORD_W-1:0]     fwd;
	logic [rkce_pkg::WORD_W-1:0]     rev;
	logic [rkce_pkg::WORD_W-1:0]     canon;

	rkce_cfg #(
		.MAX_K (MAX_K)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rkce_datapath #(
		.MAX_K (MAX_K)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_char    (s_tdata),
		.in_start   (s_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_fwd    (fwd),
		.out_rev    (rev),
		.out_canon  (canon),
		.out_kvalid (m_tuser)
	);

	assign m_tdata = {canon, rev, fwd};

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

import rkce_pkg::*;

// One k-mer word as the block should emit it
typedef struct {
	logic [WORD_W-1:0] fwd;
	logic [WORD_W-1:0] rev;
	logic [WORD_W-1:0] canon;
	logic              full;
} kmer_word_t;

// Rolling k-mer predictor plus the queue of words still owed by the block
class kmer_scoreboard;
	logic [K_W-1:0]    kmer_size;
	logic              takes_max;
	logic [CODE_W-1:0] code_a, code_t, code_c, code_g;
	logic [WORD_W-1:0] fwd_reg, rev_reg;
	int unsigned       fill;
	kmer_word_t        owed_words[$];
	int unsigned       mismatches;

	function new();
		kmer_size  = KMER_SIZE_RST;
		takes_max  = 1'b0;
		code_a     = CODE_A_RST;
		code_t     = CODE_T_RST;
		code_c     = CODE_C_RST;
		code_g     = CODE_G_RST;
		fwd_reg    = '0;
		rev_reg    = '0;
		fill       = 0;
		mismatches = 0;
	endfunction

	function int unsigned pending();
		return owed_words.size();
	endfunction

	// Register write as seen by the datapath; unknown indexes fall through
	function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_KMER_SIZE: begin
				kmer_size = val[K_W-1:0];
				fwd_reg   = '0;
				rev_reg   = '0;
				fill      = 0;
			end
			REG_CANON_MAX: takes_max = val[0];
			REG_CODE_A:    code_a = val[CODE_W-1:0];
			REG_CODE_T:    code_t = val[CODE_W-1:0];
			REG_CODE_C:    code_c = val[CODE_W-1:0];
			REG_CODE_G:    code_g = val[CODE_W-1:0];
			default: ;
		endcase
	endfunction

	// Shift one base into both rolling words and queue the resulting word
	function void note_base(input logic [CHAR_W-1:0] ch, input logic start);
		logic [CHAR_W-1:0] up;
		logic [CODE_W-1:0] fc, rc;
		logic [WORD_W-1:0] mask;
		int unsigned       k;
		kmer_word_t        w;
		up = ch;
		if (up >= 8'h61 && up <= 8'h7A)
			up = up - 8'h20;
		if (up == CHAR_A) begin
			fc = code_a;
			rc = code_t;
		end else if (up == CHAR_T) begin
			fc = code_t;
			rc = code_a;
		end else if (up == CHAR_C) begin
			fc = code_c;
			rc = code_g;
		end else begin
			fc = code_g;
			rc = code_c;
		end
		// size 0 acts as 1, anything above 32 as 32
		k = kmer_size;
		if (k < 1)
			k = 1;
		if (k > MAX_K_DEF)
			k = MAX_K_DEF;
		mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
		if (start) begin
			fwd_reg = '0;
			rev_reg = '0;
			fill    = 0;
		end
		fwd_reg = ((fwd_reg << 2) | WORD_W'(fc)) & mask;
		rev_reg = ((rev_reg & mask) >> 2) | (WORD_W'(rc) << (2 * k - 2));
		rev_reg = rev_reg & mask;
		if (fill < k)
			fill++;
		if (fill >= k) begin
			w.fwd   = fwd_reg;
			w.rev   = rev_reg;
			w.canon = (takes_max ^ (fwd_reg < rev_reg)) ? fwd_reg : rev_reg;
			w.full  = 1'b1;
		end else begin
			w.fwd   = '0;
			w.rev   = '0;
			w.canon = '0;
			w.full  = 1'b0;
		end
		owed_words.push_back(w);
	endfunction

	task report(input string what, input logic [WORD_W-1:0] got, input logic [WORD_W-1:0] want);
		if (mismatches < 40)
			$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	task check_kmer(input logic [WORD_W-1:0] fwd, input logic [WORD_W-1:0] rev,
			input logic [WORD_W-1:0] canon, input logic full);
		kmer_word_t w;
		if (owed_words.size() == 0) begin
			report("unexpected word", fwd, '0);
			return;
		end
		w = owed_words.pop_front();
		if (fwd !== w.fwd)
			report("forward_word", fwd, w.fwd);
		if (rev !== w.rev)
			report("revcomp_word", rev, w.rev);
		if (canon !== w.canon)
			report("canonical_word", canon, w.canon);
		if (full !== w.full)
			report("kmer_valid", WORD_W'(full), WORD_W'(w.full));
	endtask
endclass

module tb_top;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd7;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_BASES = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // [7:0] base_char
	logic                  s_tuser = 1'b0; // [0] start_seq
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [191:0]          m_tdata;        // [63:0] fwd, [127:64] revcomp, [191:128] canonical
	logic                  m_tuser;        // [0] kmer_valid

	int unsigned     idle_pct = 0;
	int unsigned     stall_pct = 0;
	kmer_scoreboard  sb = new();

	rolling_kmer_canonical_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_kmer(m_tdata[63:0], m_tdata[127:64], m_tdata[191:128], m_tuser);
	end

	// entered and left at a falling edge; valid stays high into the next word
	task send_base(input logic [7:0] ch, input logic start);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		sb.note_base(ch, start);
		@(negedge clk);
	endtask

	// cfg_valid is left high, the caller drops it after the last write
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// run limit
	initial begin
		#(2_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0]            dir_chars[22];
		logic                  dir_starts[22];
		logic [CFG_DATA_W-1:0] k_val, max_val;
		logic [CFG_DATA_W-1:0] codes[4];
		logic                  start;
		logic [7:0]            ch;
		int unsigned           k_eff;

		dir_chars = '{"A", "C", "G", "T", "a", "c", "g", "t", "X", "x", "N",
			8'h00, 8'hFF, 8'h80, 8'h7F, "T", "A", "A", "A", "G", "c", "t"};
		dir_starts = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1, 0, 0, 0, 1, 1, 0};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: k of 32 stays short of a full word here
		send_base("A", 1'b1);
		send_base("G", 1'b0);
		send_base("c", 1'b0);
		drain();

		// short k for the directed characters
		write_reg(REG_KMER_SIZE, 6'd4);
		cfg_valid <= 1'b0;
		@(negedge clk);
		for (int i = 0; i < 22; i++)
			send_base(dir_chars[i], dir_starts[i]);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// extremes of k and mode first, random settings after
			case (ph)
				0: k_val = 6'd1;
				1: k_val = 6'd32;
				2: k_val = 6'd0;
				3: k_val = 6'd33;
				4: k_val = 6'd63;
				default: k_val = ($urandom_range(0, 7) == 0) ?
					CFG_DATA_W'($urandom_range(0, 63)) : CFG_DATA_W'($urandom_range(2, 12));
			endcase
			if (ph == 0)
				max_val = 6'd0;
			else if (ph == 1)
				max_val = 6'd1;
			else
				max_val = CFG_DATA_W'($urandom_range(0, 63));
			for (int c = 0; c < 4; c++) begin
				if (ph < 2)
					codes[c] = CFG_DATA_W'(c);
				else if (ph == 2)
					codes[c] = 6'h3E;  // every base shares one code
				else
					codes[c] = CFG_DATA_W'($urandom_range(0, 63));
			end
			// kmer_size goes first or last, the fill restarts either way
			if (ph[0])
				write_reg(REG_KMER_SIZE, k_val);
			write_reg(REG_CANON_MAX, max_val);
			write_reg(REG_CODE_A, codes[0]);
			write_reg(REG_CODE_T, codes[1]);
			write_reg(REG_CODE_C, codes[2]);
			write_reg(REG_CODE_G, codes[3]);
			write_reg(ph[1] ? REG_SPARE_1 : REG_SPARE_0, CFG_DATA_W'($urandom_range(0, 63)));
			if (!ph[0])
				write_reg(REG_KMER_SIZE, k_val);
			cfg_valid <= 1'b0;

			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			@(negedge clk);

			k_eff = (k_val == 0) ? 1 : ((k_val > MAX_K_DEF) ? MAX_K_DEF : k_val);
			for (int i = 0; i < PHASE_BASES; i++) begin
				// mostly real bases, sometimes any byte
				if ($urandom_range(0, 99) < 85) begin
					case ($urandom_range(0, 3))
						0: ch = CHAR_A;
						1: ch = CHAR_C;
						2: ch = CHAR_T;
						default: ch = 8'h47;
					endcase
					if ($urandom_range(0, 1))
						ch = ch | 8'h20;
				end else begin
					ch = 8'($urandom_range(0, 255));
				end
				// runs long enough to fill a word most of the time
				start = (i == 0 && $urandom_range(0, 1)) ||
					($urandom_range(0, 3 * k_eff + 6) == 0);
				// hold off once until the block has caught up
				if (ph == 6 && i == 30) begin
					s_tvalid <= 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
				send_base(ch, start);
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
